### hdl/rpnh_pkg.sv
// Shared widths, register indexes and status types for the ray polygon nearest hit unit.
// No dependencies.
`default_nettype none
package rpnh_pkg;

  localparam int CoordW = 32;
  localparam int DirW   = 16;
  localparam int DiffW  = 33;
  localparam int DetW   = 50;
  localparam int NtW    = 67;
  localparam int DivW   = 82;
  localparam int DistW  = 32;
  localparam int CfgIdxW = 8;
  localparam int CountW = 9;
  localparam int TShift = 14;

  localparam logic [CfgIdxW-1:0] CfgVertexCount  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgParThreshold = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgMinDistance  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgDefDistance  = 8'd3;

  localparam logic [DistW-1:0] MinDistReset = 32'd10;
  localparam logic [DistW-1:0] DefDistReset = 32'd500000;

  typedef struct packed {
    logic done;
    logic sat;
    logic rem_nz;
  } div_status_t;

  typedef struct packed {
    logic valid;
    logic pass;
  } edge_status_t;

endpackage
`default_nettype wire

### hdl/rpnh_vertex_mem.sv
// Vertex store: x and y arrays, one write port, one registered read port.
// Depends on rpnh_pkg.
`default_nettype none
module rpnh_vertex_mem #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AddrW-1:0]              waddr_i,
  input  wire logic [rpnh_pkg::CoordW-1:0]   wx_i,
  input  wire logic [rpnh_pkg::CoordW-1:0]   wy_i,
  input  wire logic                          re_i,
  input  wire logic [AddrW-1:0]              raddr_i,
  output logic      [rpnh_pkg::CoordW-1:0]   rx_o,
  output logic      [rpnh_pkg::CoordW-1:0]   ry_o
);
  import rpnh_pkg::*;

  logic [CoordW-1:0] mem_x [Depth];
  logic [CoordW-1:0] mem_y [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
    if (re_i) begin
      rx_o <= mem_x[raddr_i];
      ry_o <= mem_y[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/rpnh_edge_calc.sv
// Four-stage edge test: differences, products, determinant sums, sign fix and checks.
// Depends on rpnh_pkg.
`default_nettype none
module rpnh_edge_calc (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                load_i,
  input  wire logic signed [rpnh_pkg::CoordW-1:0]  p1x_i,
  input  wire logic signed [rpnh_pkg::CoordW-1:0]  p1y_i,
  input  wire logic signed [rpnh_pkg::CoordW-1:0]  p2x_i,
  input  wire logic signed [rpnh_pkg::CoordW-1:0]  p2y_i,
  input  wire logic signed [rpnh_pkg::CoordW-1:0]  ox_i,
  input  wire logic signed [rpnh_pkg::CoordW-1:0]  oy_i,
  input  wire logic signed [rpnh_pkg::DirW-1:0]    dx_i,
  input  wire logic signed [rpnh_pkg::DirW-1:0]    dy_i,
  input  wire logic        [rpnh_pkg::DistW-1:0]   thr_i,
  output rpnh_pkg::edge_status_t                   status_o,
  output logic             [rpnh_pkg::DivW-1:0]    tm_o,
  output logic             [rpnh_pkg::DetW-1:0]    dm_o
);
  import rpnh_pkg::*;

  logic [3:0] v_q;
  logic signed [DiffW-1:0] vx_q, vy_q, wx_q, wy_q;
  logic signed [DirW-1:0]  dx_q, dy_q;
  logic signed [DirW+DiffW-1:0] pdyvx_q, pdxvy_q, pdxwy_q, pdywx_q;
  logic signed [2*DiffW-1:0]    pvxwy_q, pvywx_q;
  logic signed [DetW-1:0] det_q, nu_q;
  logic signed [NtW-1:0]  nt_q;
  logic signed [DetW-1:0] adet, anu;
  logic signed [NtW-1:0]  ant;
  logic pass_d, pass_q;

  always_comb begin
    adet = det_q[DetW-1] ? -det_q : det_q;
    anu  = det_q[DetW-1] ? -nu_q  : nu_q;
    ant  = det_q[DetW-1] ? -nt_q  : nt_q;
    pass_d = ($unsigned(adet) > DetW'(thr_i)) && !anu[DetW-1] && (anu <= adet)
             && !ant[NtW-1] && (ant != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], load_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vx_q <= DiffW'(p2x_i) - DiffW'(p1x_i);
      vy_q <= DiffW'(p2y_i) - DiffW'(p1y_i);
      wx_q <= DiffW'(ox_i) - DiffW'(p1x_i);
      wy_q <= DiffW'(oy_i) - DiffW'(p1y_i);
      dx_q <= dx_i;
      dy_q <= dy_i;
    end
    pdyvx_q <= dy_q * vx_q;
    pdxvy_q <= dx_q * vy_q;
    pdxwy_q <= dx_q * wy_q;
    pdywx_q <= dy_q * wx_q;
    pvxwy_q <= vx_q * wy_q;
    pvywx_q <= vy_q * wx_q;
    det_q <= DetW'(pdyvx_q) - DetW'(pdxvy_q);
    nu_q  <= DetW'(pdxwy_q) - DetW'(pdywx_q);
    nt_q  <= NtW'(pvxwy_q) - NtW'(pvywx_q);
    if (v_q[2]) begin
      pass_q <= pass_d;
      tm_o   <= DivW'($unsigned(ant)) << TShift;
      dm_o   <= $unsigned(adet);
    end
  end

  assign status_o.valid = v_q[3];
  assign status_o.pass  = pass_q;

endmodule
`default_nettype wire

### hdl/rpnh_divider.sv
// Restoring divider, one quotient bit per cycle, with saturation and remainder flag.
// Depends on rpnh_pkg.
`default_nettype none
module rpnh_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [rpnh_pkg::DivW-1:0]    num_i,
  input  wire logic [rpnh_pkg::DetW-1:0]    den_i,
  output rpnh_pkg::div_status_t             status_o,
  output logic      [rpnh_pkg::DistW-1:0]   quot_o
);
  import rpnh_pkg::*;

  localparam int StepW = $clog2(DistW + 1);

  logic             busy_q, done_q, sat_q;
  logic [StepW-1:0] step_q;
  logic [DivW-1:0]  rem_q, den_q;
  logic             ge;

  assign ge = rem_q >= den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && ((step_q == StepW'(DistW) && ge) || step_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= DivW'(den_i) << DistW;
      step_q <= StepW'(DistW);
      sat_q  <= 1'b0;
      quot_o <= '0;
    end else if (busy_q) begin
      den_q <= den_q >> 1;
      if (step_q == StepW'(DistW)) begin
        sat_q <= ge;
        if (ge) quot_o <= '1;
      end else begin
        quot_o <= {quot_o[DistW-2:0], ge};
        if (ge) rem_q <= rem_q - den_q;
      end
      if (step_q != '0) step_q <= step_q - 1'b1;
    end
  end

  assign status_o.done   = done_q;
  assign status_o.sat    = sat_q;
  assign status_o.rem_nz = (rem_q != '0);

endmodule
`default_nettype wire

### hdl/ray_polygon_nearest_hit_unit.sv
// Top level: configuration registers, query sequencer, vertex store, edge unit, divider.
// Depends on rpnh_pkg, rpnh_vertex_mem, rpnh_edge_calc, rpnh_divider.
//
//  channel | signals                                        | dir
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i   | in
//  in      | in_valid_i in_ready_o mode_i vertex_index_i ...  | in
//  out     | out_valid_o out_ready_i distance_o hit_o         | out
//
// A vertex write is taken while idle. A query runs each edge through the edge unit, and an
// edge that passes the tests also through the 33-step divider, which stops after its first
// step when t saturates. The edge walk reads the single vertex store port once per edge.
// Reset clears control and configuration; vertex storage is undefined until written.
// A finished result waits in the output word; a new word is taken while it waits.
`default_nettype none
module ray_polygon_nearest_hit_unit #(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic        [rpnh_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic        [rpnh_pkg::DistW-1:0]   cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                mode_i,
  input  wire logic        [7:0]                   vertex_index_i,
  input  wire logic signed [rpnh_pkg::CoordW-1:0]  point_x_i,
  input  wire logic signed [rpnh_pkg::CoordW-1:0]  point_y_i,
  input  wire logic signed [rpnh_pkg::DirW-1:0]    dir_x_i,
  input  wire logic signed [rpnh_pkg::DirW-1:0]    dir_y_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic             [rpnh_pkg::DistW-1:0]   distance_o,
  output logic                                     hit_o
);
  import rpnh_pkg::*;

  localparam int AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CntW  = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    StIdle, StFirst, StEdge, StCalc, StDiv, StFinish
  } state_e;

  state_e state_q;
  logic [CountW-1:0] count_q;
  logic [DistW-1:0]  thr_q, min_q, def_q;
  logic [CntW-1:0]   n_q, i_q, n_d, k;
  logic signed [CoordW-1:0] ox_q, oy_q, p1x_q, p1y_q;
  logic signed [DirW-1:0]   dx_q, dy_q;
  logic [DistW-1:0]  best_q, t_cand;
  logic              found_q, cand_ok, last_edge;
  logic              in_acc, mem_we, mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [CoordW-1:0] rx, ry;
  edge_status_t      edge_st;
  div_status_t       div_st;
  logic [DivW-1:0]   tm;
  logic [DetW-1:0]   dm;
  logic [DistW-1:0]  quot;
  logic              div_start;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign mem_we      = in_acc && !mode_i && (32'(vertex_index_i) < 32'(MAX_VERTICES));

  always_comb begin
    if (32'(count_q) > 32'(MAX_VERTICES)) n_d = CntW'(MAX_VERTICES);
    else n_d = CntW'(count_q);
    last_edge = (i_q + 1'b1 == n_q);
    k = (i_q + CntW'(2) == n_q) ? '0 : i_q + CntW'(2);
    t_cand  = div_st.sat ? '1 : quot;
    cand_ok = div_st.sat || (quot > min_q) || (quot == min_q && div_st.rem_nz);
    div_start = (state_q == StCalc) && edge_st.valid && edge_st.pass;
    mem_re = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      StIdle: begin
        mem_re = in_acc && mode_i;
      end
      StFirst: begin
        mem_re = 1'b1;
        mem_raddr = AddrW'(1);
      end
      StCalc: begin
        mem_re = edge_st.valid && !edge_st.pass && !last_edge;
        mem_raddr = k[AddrW-1:0];
      end
      StDiv: begin
        mem_re = div_st.done && !last_edge;
        mem_raddr = k[AddrW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      thr_q <= '0;
      min_q <= MinDistReset;
      def_q <= DefDistReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgVertexCount:  count_q <= cfg_data_i[CountW-1:0];
        CfgParThreshold: thr_q <= cfg_data_i;
        CfgMinDistance:  min_q <= cfg_data_i;
        CfgDefDistance:  def_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_o <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_acc && mode_i) begin
            found_q <= 1'b0;
            state_q <= (n_d < CntW'(3)) ? StFinish : StFirst;
          end
        end
        StFirst: state_q <= StEdge;
        StEdge:  state_q <= StCalc;
        StCalc: begin
          if (edge_st.valid) begin
            if (edge_st.pass) state_q <= StDiv;
            else state_q <= last_edge ? StFinish : StEdge;
          end
        end
        StDiv: begin
          if (div_st.done) begin
            if (cand_ok && (!found_q || t_cand < best_q)) found_q <= 1'b1;
            state_q <= last_edge ? StFinish : StEdge;
          end
        end
        StFinish: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && mode_i) begin
      ox_q <= point_x_i;
      oy_q <= point_y_i;
      dx_q <= dir_x_i;
      dy_q <= dir_y_i;
      n_q  <= n_d;
      i_q  <= '0;
    end
    if (state_q == StFirst || state_q == StEdge) begin
      p1x_q <= rx;
      p1y_q <= ry;
    end
    if ((state_q == StCalc && edge_st.valid && !edge_st.pass) ||
        (state_q == StDiv && div_st.done)) begin
      i_q <= i_q + 1'b1;
    end
    if (state_q == StDiv && div_st.done && cand_ok && (!found_q || t_cand < best_q)) begin
      best_q <= t_cand;
    end
    if (state_q == StFinish && (!out_valid_o || out_ready_i)) begin
      distance_o <= found_q ? best_q : def_q;
      hit_o <= found_q;
    end
  end

  rpnh_vertex_mem #(
    .Depth(MAX_VERTICES),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(AddrW'(vertex_index_i)),
    .wx_i   (point_x_i),
    .wy_i   (point_y_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rx_o   (rx),
    .ry_o   (ry)
  );

  rpnh_edge_calc u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (state_q == StEdge),
    .p1x_i   (p1x_q),
    .p1y_i   (p1y_q),
    .p2x_i   ($signed(rx)),
    .p2y_i   ($signed(ry)),
    .ox_i    (ox_q),
    .oy_i    (oy_q),
    .dx_i    (dx_q),
    .dy_i    (dy_q),
    .thr_i   (thr_q),
    .status_o(edge_st),
    .tm_o    (tm),
    .dm_o    (dm)
  );

  rpnh_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tm),
    .den_i   (dm),
    .status_o(div_st),
    .quot_o  (quot)
  );

endmodule
`default_nettype wire

### hdl/rpnh_checker.sv
// Port-level checks for ray_polygon_nearest_hit_unit, attached by bind.
// Depends on rpnh_pkg and the top level's ports.
`default_nettype none
module rpnh_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic                                mode_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic        [rpnh_pkg::DistW-1:0]   distance_o,
  input wire logic                                hit_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) && $stable(hit_o))
    else $error("result word changed while stalled");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i |=> !in_ready_o)
    else $error("input taken again right after a query");

  a_write_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !mode_i |=> in_ready_o)
    else $error("vertex write did not finish in one cycle");

  a_result_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result word without a query in flight");

endmodule

bind ray_polygon_nearest_hit_unit rpnh_checker u_rpnh_checker (.*);
`default_nettype wire
